### design/mic_pkg.sv
// ----------------------------------------------------------------------------
// mic_pkg: shared types and constants for the cofactor matrix inverter
// Field widths, the job token passed from loader to compute engine, and
// the permutation tables used to expand small minors.
// ----------------------------------------------------------------------------
package mic_pkg;

   localparam int MAX_ORDER_DEFAULT = 4;
   localparam int ENTRY_W = 8;
   localparam int SIZE_W = 3;
   localparam int IDX_W = 2;
   localparam int MINOR_W = 25;
   localparam int DET_W = 34;
   localparam int FRAC_W = 16;
   localparam int QUO_W = MINOR_W + FRAC_W;
   localparam int INV_W = QUO_W + 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;
   localparam logic [SIZE_W-1:0] SIZE_MIN = 3'd2;

   typedef struct packed {
      logic [SIZE_W-1:0] order;
   } job_type;

   // Column order of each term of a 3x3 expansion, row 0 in the low bits.
   localparam logic [5:0] PERM3 [0:5] = '{
      {2'd2, 2'd1, 2'd0}, {2'd1, 2'd2, 2'd0}, {2'd2, 2'd0, 2'd1},
      {2'd0, 2'd2, 2'd1}, {2'd1, 2'd0, 2'd2}, {2'd0, 2'd1, 2'd2}};
   localparam logic [5:0] PERM3_NEG = 6'b100110;

   function automatic logic [2:0] perm_count(input logic [1:0] k);
      logic [2:0] cnt;
      case (k)
         2'd3: cnt = 3'd6;
         2'd2: cnt = 3'd2;
         default: cnt = 3'd1;
      endcase
      return cnt;
   endfunction

   function automatic logic [1:0] perm_col(input logic [1:0] k, input logic [2:0] t,
                                           input logic [1:0] i);
      logic [5:0] row;
      logic [1:0] col;
      row = PERM3[t];
      case (k)
         2'd3: col = 2'(row >> {i, 1'b0});
         2'd2: col = t[0] ? {1'b0, ~i[0]} : i;
         default: col = 2'd0;
      endcase
      return col;
   endfunction

   function automatic logic perm_neg(input logic [1:0] k, input logic [2:0] t);
      logic neg;
      case (k)
         2'd3: neg = PERM3_NEG[t];
         2'd2: neg = t[0];
         default: neg = 1'b0;
      endcase
      return neg;
   endfunction

endpackage

### design/mic_front.sv
// ----------------------------------------------------------------------------
// mic_front: entry loader
// Hold the size register, count entries of a run, write them into the
// matrix store and issue a job token when the matrix is complete.
// ----------------------------------------------------------------------------
module mic_front #(
   parameter int MAX_ORDER = mic_pkg::MAX_ORDER_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [mic_pkg::ENTRY_W-1:0]    entry,
   input  logic                           csr_we,
   input  logic [mic_pkg::SIZE_W-1:0]     csr_wdata,
   output logic                           push,
   output mic_pkg::job_type               job,
   input  logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] rd_addr,
   output logic [mic_pkg::ENTRY_W-1:0]    rd_data
);
   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [mic_pkg::SIZE_W-1:0] size_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [mic_pkg::SIZE_W-1:0] order;
   logic [CNT_W-1:0] total, base, nxt;
   logic [mic_pkg::ENTRY_W-1:0] matrix_store_ff [DEPTH];
   logic [mic_pkg::ENTRY_W-1:0] rd_data_ff;

   always_comb begin
      if (size_ff < mic_pkg::SIZE_MIN) begin
         order = mic_pkg::SIZE_MIN;
      end else if (size_ff > mic_pkg::SIZE_W'(MAX_ORDER)) begin
         order = mic_pkg::SIZE_W'(MAX_ORDER);
      end else begin
         order = size_ff;
      end
      total = CNT_W'(CNT_W'(order) * CNT_W'(order));
      base = (count_ff >= total) ? '0 : count_ff;
      nxt = base + 1'b1;
      push = accept && (nxt == total);
      job.order = order;
      count_in = count_ff;
      if (csr_we) begin
         count_in = '0;
      end else if (accept) begin
         count_in = push ? '0 : nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mic_pkg::SIZE_RESET;
         count_ff <= '0;
      end else begin
         if (csr_we) begin
            size_ff <= csr_wdata;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         matrix_store_ff[base[ADDR_W-1:0]] <= entry;
      end
      rd_data_ff <= matrix_store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mic_queue.sv
// ----------------------------------------------------------------------------
// mic_queue: job token queue
// Short FIFO of job tokens between the loader and the compute engine.
// ----------------------------------------------------------------------------
module mic_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mic_pkg::job_type push_job,
   input  logic             pop,
   output logic             empty,
   output mic_pkg::job_type head
);
   localparam int PTR_W = $clog2(mic_pkg::QUEUE_DEPTH);

   mic_pkg::job_type slot_ff [mic_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0] fill_ff;
   logic do_push, do_pop;

   assign empty = (fill_ff == '0);
   assign head = slot_ff[rd_ptr_ff];
   assign do_push = push && (fill_ff != (PTR_W+1)'(mic_pkg::QUEUE_DEPTH));
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/mic_div.sv
// ----------------------------------------------------------------------------
// mic_div: restoring divider
// One quotient bit per cycle on magnitudes, sign applied at the end.
// ----------------------------------------------------------------------------
module mic_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mic_pkg::QUO_W-1:0]           dividend,
   input  logic [mic_pkg::DET_W-1:0]           divisor,
   input  logic                                negate,
   output logic                                done,
   output logic signed [mic_pkg::INV_W-1:0]    quotient
);
   localparam int BIT_W = $clog2(mic_pkg::QUO_W + 1);

   logic active_ff, done_ff, neg_ff;
   logic [BIT_W-1:0] bits_ff;
   logic [mic_pkg::DET_W-1:0] rem_ff, div_ff;
   logic [mic_pkg::QUO_W-1:0] quo_ff;
   logic [mic_pkg::DET_W:0] trial, diff;
   logic take;

   always_comb begin
      trial = {rem_ff, quo_ff[mic_pkg::QUO_W-1]};
      diff = trial - {1'b0, div_ff};
      take = (trial >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
         end else if (active_ff && bits_ff == BIT_W'(1)) begin
            active_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
         neg_ff <= negate;
         bits_ff <= BIT_W'(mic_pkg::QUO_W);
      end else if (active_ff) begin
         rem_ff <= take ? diff[mic_pkg::DET_W-1:0] : trial[mic_pkg::DET_W-1:0];
         quo_ff <= {quo_ff[mic_pkg::QUO_W-2:0], take};
         bits_ff <= bits_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

### design/mic_back.sv
// ----------------------------------------------------------------------------
// mic_back: determinant and adjugate engine
// Expand minors term by term over the store read port, sum the determinant,
// then each adjugate entry with its scaled quotient, or one singular result.
// ----------------------------------------------------------------------------
module mic_back #(
   parameter int MAX_ORDER = mic_pkg::MAX_ORDER_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   job_empty,
   input  mic_pkg::job_type                       job_head,
   output logic                                   pop,
   output logic                                   active,
   output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] rd_addr,
   input  logic [mic_pkg::ENTRY_W-1:0]            rd_data,
   output logic                                   rsp_valid,
   output logic [mic_pkg::IDX_W-1:0]              rsp_row_index,
   output logic [mic_pkg::IDX_W-1:0]              rsp_column_index,
   output logic signed [mic_pkg::INV_W-1:0]       rsp_inverse_value,
   output logic signed [mic_pkg::MINOR_W-1:0]     rsp_adjugate_value,
   output logic signed [mic_pkg::DET_W-1:0]       rsp_determinant,
   output logic                                   rsp_singular,
   output logic                                   rsp_last_result
);
   localparam int ADDR_W = $clog2(MAX_ORDER * MAX_ORDER);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_RD    = 11'b00000000010,
      S_MUL   = 11'b00000000100,
      S_TERM  = 11'b00000001000,
      S_DRD   = 11'b00000010000,
      S_DMUL  = 11'b00000100000,
      S_DACC  = 11'b00001000000,
      S_CHECK = 11'b00010000000,
      S_COF   = 11'b00100000000,
      S_DIV   = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff;
   logic out_phase_ff;
   logic [mic_pkg::SIZE_W-1:0] n_ff;
   logic [1:0] c_ff, oi_ff, oj_ff, i_ff;
   logic [2:0] t_ff;
   logic signed [mic_pkg::MINOR_W-1:0] prod_ff, minor_ff, cof_ff;
   logic signed [mic_pkg::DET_W-1:0] dprod_ff, det_ff;
   logic valid_ff, singular_ff, last_ff;
   logic [mic_pkg::IDX_W-1:0] row_ff, col_ff;
   logic signed [mic_pkg::INV_W-1:0] inv_ff;

   logic [1:0] k, skip_r, skip_c, pc, row, col, last_idx;
   logic [5:0] lin;
   logic signed [mic_pkg::ENTRY_W-1:0] rd_s;
   logic [mic_pkg::MINOR_W-1:0] minor_mag;
   logic [mic_pkg::DET_W-1:0] det_mag;
   logic div_start, div_done;
   logic signed [mic_pkg::INV_W-1:0] div_q;

   always_comb begin
      k = 2'(n_ff - 1'b1);
      last_idx = k;
      skip_r = out_phase_ff ? oj_ff : 2'd0;
      skip_c = out_phase_ff ? oi_ff : c_ff;
      pc = mic_pkg::perm_col(k, t_ff, i_ff);
      row = i_ff + {1'b0, (i_ff >= skip_r)};
      col = pc + {1'b0, (pc >= skip_c)};
      lin = 6'(row * n_ff) + 6'(col);
      rd_addr = (state_ff == S_DRD) ? ADDR_W'(c_ff) : ADDR_W'(lin);
      rd_s = $signed(rd_data);
      minor_mag = minor_ff[mic_pkg::MINOR_W-1] ? 25'(-minor_ff) : minor_ff;
      det_mag = det_ff[mic_pkg::DET_W-1] ? 34'(-det_ff) : det_ff;
      div_start = (state_ff == S_COF);
      pop = (state_ff == S_IDLE) && !job_empty;
      active = (state_ff != S_IDLE);
   end

   mic_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({minor_mag, {mic_pkg::FRAC_W{1'b0}}}),
      .divisor  (det_mag),
      .negate   (minor_ff[mic_pkg::MINOR_W-1] ^ (oi_ff[0] ^ oj_ff[0])
                 ^ det_ff[mic_pkg::DET_W-1]),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!job_empty) begin
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_MUL;
            S_MUL: begin
               state_ff <= (i_ff == k - 1'b1) ? S_TERM : S_RD;
            end
            S_TERM: begin
               if (t_ff == mic_pkg::perm_count(k) - 1'b1) begin
                  state_ff <= out_phase_ff ? S_COF : S_DRD;
               end else begin
                  state_ff <= S_RD;
               end
            end
            S_DRD: state_ff <= S_DMUL;
            S_DMUL: state_ff <= S_DACC;
            S_DACC: state_ff <= (c_ff == last_idx) ? S_CHECK : S_RD;
            S_CHECK: begin
               if (det_ff == '0) begin
                  valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_RD;
               end
            end
            S_COF: state_ff <= S_DIV;
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               valid_ff <= 1'b1;
               state_ff <= (oi_ff == last_idx && oj_ff == last_idx) ? S_IDLE : S_RD;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Datapath: counters and accumulators follow the state register.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            n_ff <= job_head.order;
            out_phase_ff <= 1'b0;
            c_ff <= '0;
            det_ff <= '0;
            t_ff <= '0;
            i_ff <= '0;
            prod_ff <= 25'sd1;
            minor_ff <= '0;
         end
         S_MUL: begin
            prod_ff <= 25'(prod_ff * rd_s);
            i_ff <= i_ff + 1'b1;
         end
         S_TERM: begin
            minor_ff <= mic_pkg::perm_neg(k, t_ff) ? minor_ff - prod_ff : minor_ff + prod_ff;
            t_ff <= t_ff + 1'b1;
            i_ff <= '0;
            prod_ff <= 25'sd1;
         end
         S_DMUL: dprod_ff <= 34'(minor_ff * rd_s);
         S_DACC: begin
            det_ff <= c_ff[0] ? det_ff - dprod_ff : det_ff + dprod_ff;
            c_ff <= c_ff + 1'b1;
            t_ff <= '0;
            minor_ff <= '0;
         end
         S_CHECK: begin
            out_phase_ff <= 1'b1;
            oi_ff <= '0;
            oj_ff <= '0;
            row_ff <= '0;
            col_ff <= '0;
            inv_ff <= '0;
            cof_ff <= '0;
            singular_ff <= 1'b1;
            last_ff <= 1'b1;
         end
         S_COF: begin
            cof_ff <= (oi_ff[0] ^ oj_ff[0]) ? -minor_ff : minor_ff;
         end
         S_DIV: begin
            inv_ff <= div_q;
            row_ff <= oi_ff;
            col_ff <= oj_ff;
            singular_ff <= 1'b0;
            last_ff <= (oi_ff == last_idx && oj_ff == last_idx);
         end
         S_DONE: begin
            t_ff <= '0;
            minor_ff <= '0;
            if (oj_ff == last_idx) begin
               oj_ff <= '0;
               oi_ff <= oi_ff + 1'b1;
            end else begin
               oj_ff <= oj_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = valid_ff;
   assign rsp_row_index = row_ff;
   assign rsp_column_index = col_ff;
   assign rsp_inverse_value = inv_ff;
   assign rsp_adjugate_value = cof_ff;
   assign rsp_determinant = singular_ff ? '0 : det_ff;
   assign rsp_singular = singular_ff;
   assign rsp_last_result = last_ff;

endmodule

### design/matrix_inverse_by_cofactors.sv
// ----------------------------------------------------------------------------
// matrix_inverse_by_cofactors: integer matrix inverse by the adjugate method
// Load an n x n signed matrix one entry per item, then emit the adjugate
// and the Q.16 inverse, or one singular result.
// ----------------------------------------------------------------------------
// Usage:
//  - Write csr_write_data with csr_write_enable to set the order n (2..4,
//    out-of-range values clamp); any write restarts loading.
//  - Drive start with req_entry_value; an item is taken at an edge where
//    start is high and busy low. Entries go in row-major order, one per
//    cycle while loading.
//  - The item that completes the matrix raises busy until the run is out.
//    The engine expands each minor term by term through the single store
//    read port (a read state and a multiply state per entry), accumulates
//    the determinant, then per result forms one cofactor and runs a 41-bit
//    bit-serial divider.
//  - Each result sits on the rsp_ ports for one cycle with rsp_valid high;
//    the receiver cannot stall it. Row-major order, rsp_last_result on the
//    final one. A zero determinant gives one result with rsp_singular set.
//  - Synchronous reset sets the order to 4, clears the entry count, the
//    job queue and the engine. The store itself is not cleared.
// ----------------------------------------------------------------------------
module matrix_inverse_by_cofactors #(
   parameter int MAX_ORDER = mic_pkg::MAX_ORDER_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [mic_pkg::ENTRY_W-1:0]   req_entry_value,
   input  logic                                 csr_write_enable,
   input  logic [mic_pkg::SIZE_W-1:0]           csr_write_data,
   output logic                                 rsp_valid,
   output logic [mic_pkg::IDX_W-1:0]            rsp_row_index,
   output logic [mic_pkg::IDX_W-1:0]            rsp_column_index,
   output logic signed [mic_pkg::INV_W-1:0]     rsp_inverse_value,
   output logic signed [mic_pkg::MINOR_W-1:0]   rsp_adjugate_value,
   output logic signed [mic_pkg::DET_W-1:0]     rsp_determinant,
   output logic                                 rsp_singular,
   output logic                                 rsp_last_result
);
   localparam int ADDR_W = $clog2(MAX_ORDER * MAX_ORDER);

   logic accept, push, pop, q_empty, back_active;
   mic_pkg::job_type push_job, head_job;
   logic [ADDR_W-1:0] rd_addr;
   logic [mic_pkg::ENTRY_W-1:0] rd_data;

   // Hold off new entries while a job waits or the engine works the store.
   assign busy = !q_empty || back_active;
   assign accept = start && !busy;

   mic_front #(.MAX_ORDER(MAX_ORDER)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .entry     (req_entry_value),
      .csr_we    (csr_write_enable),
      .csr_wdata (csr_write_data),
      .push      (push),
      .job       (push_job),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   mic_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .empty    (q_empty),
      .head     (head_job)
   );

   mic_back #(.MAX_ORDER(MAX_ORDER)) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_empty          (q_empty),
      .job_head           (head_job),
      .pop                (pop),
      .active             (back_active),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_row_index      (rsp_row_index),
      .rsp_column_index   (rsp_column_index),
      .rsp_inverse_value  (rsp_inverse_value),
      .rsp_adjugate_value (rsp_adjugate_value),
      .rsp_determinant    (rsp_determinant),
      .rsp_singular       (rsp_singular),
      .rsp_last_result    (rsp_last_result)
   );

   // A singular run ends in its only result.
   a_singular_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_last_result)
      else $error("singular result without last flag");

   // A regular result always carries a nonzero determinant.
   a_det_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_singular |-> rsp_determinant != '0)
      else $error("regular result with zero determinant");

   // The last result of a run is never followed at once by another.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |=> !rsp_valid)
      else $error("result right after end of run");

   // No new entry is taken while a completed matrix waits for the engine.
   a_no_load_when_queued: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> !accept)
      else $error("entry taken while a job is pending");

endmodule

### sim/tb_matrix_inverse_by_cofactors.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_by_cofactors: self-checking bench for the cofactor inverter
// Loads square matrices entry by entry, predicts the adjugate, the Q.16
// inverse and the determinant of each, and compares every strobed result
// field by field. A directed table comes first, then random matrices under
// several sender idling mixes and order settings.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_by_cofactors;

   // Kinds of rows in the directed table: load one entry or write the order.
   typedef enum logic {ROW_ENTRY, ROW_ORDER} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           value;
      bit           has_det;   // typed determinant on the row that completes a matrix
      longint       det;
   } table_row_type;

   typedef struct {
      logic [mic_pkg::IDX_W-1:0]   row;
      logic [mic_pkg::IDX_W-1:0]   col;
      logic [mic_pkg::INV_W-1:0]   inv;
      logic [mic_pkg::MINOR_W-1:0] adj;
      logic [mic_pkg::DET_W-1:0]   det;
      logic                        sing;
      logic                        last;
   } inv_entry_type;

   typedef longint mat_type [4][4];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [mic_pkg::ENTRY_W-1:0] req_entry_value = '0;
   logic csr_write_enable = 1'b0;
   logic [mic_pkg::SIZE_W-1:0] csr_write_data = '0;
   logic rsp_valid;
   logic [mic_pkg::IDX_W-1:0] rsp_row_index, rsp_column_index;
   logic signed [mic_pkg::INV_W-1:0] rsp_inverse_value;
   logic signed [mic_pkg::MINOR_W-1:0] rsp_adjugate_value;
   logic signed [mic_pkg::DET_W-1:0] rsp_determinant;
   logic rsp_singular, rsp_last_result;

   matrix_inverse_by_cofactors dut (
      .clock, .reset, .start, .busy, .req_entry_value,
      .csr_write_enable, .csr_write_data,
      .rsp_valid, .rsp_row_index, .rsp_column_index, .rsp_inverse_value,
      .rsp_adjugate_value, .rsp_determinant, .rsp_singular, .rsp_last_result
   );

   always #1 clock = ~clock;

   // Shadow of the block: stored entries, load count and order register.
   logic signed [mic_pkg::ENTRY_W-1:0] shadow_store [16];
   int unsigned shadow_loaded;
   logic [mic_pkg::SIZE_W-1:0] shadow_order;
   longint last_det;           // determinant of the most recent full matrix

   inv_entry_type pending_results[$];
   bit failed = 1'b0;
   int sender_idle_pct = 0;

   // Copy src of order k without row r and column c.
   function automatic void strike(input mat_type src, input int k, input int r,
                                  input int c, output mat_type dst);
      int di, dj;
      dst = '{default: 0};
      di = 0;
      for (int i = 0; i < k; i++) begin
         if (i == r) continue;
         dj = 0;
         for (int j = 0; j < k; j++) begin
            if (j == c) continue;
            dst[di][dj] = src[i][j];
            dj++;
         end
         di++;
      end
   endfunction

   // Determinant for orders 1..3, row-0 expansion.
   function automatic longint minor_det(input mat_type m, input int k);
      mat_type sub;
      longint sum;
      sum = 0;
      if (k == 1) return m[0][0];
      if (k == 2) return m[0][0] * m[1][1] - m[0][1] * m[1][0];
      for (int c = 0; c < 3; c++) begin
         strike(m, 3, 0, c, sub);
         sum += ((c & 1) ? -1 : 1) * m[0][c]
                * (sub[0][0] * sub[1][1] - sub[0][1] * sub[1][0]);
      end
      return sum;
   endfunction

   function automatic longint matrix_det(input mat_type m, input int k);
      mat_type sub;
      longint sum;
      sum = 0;
      if (k < 4) return minor_det(m, k);
      for (int c = 0; c < 4; c++) begin
         strike(m, 4, 0, c, sub);
         sum += ((c & 1) ? -1 : 1) * m[0][c] * minor_det(sub, 3);
      end
      return sum;
   endfunction

   function automatic int active_order();
      if (shadow_order < mic_pkg::SIZE_MIN) return 2;
      if (shadow_order > 3'd4) return 4;
      return int'(shadow_order);
   endfunction

   // Store one accepted entry; on the entry that completes the matrix,
   // queue the whole adjugate/inverse sequence.
   function automatic void load_entry(input logic signed [mic_pkg::ENTRY_W-1:0] v);
      int n;
      mat_type m, sub;
      longint cof, inv;
      inv_entry_type e;
      n = active_order();
      if (shadow_loaded >= n * n) shadow_loaded = 0;
      shadow_store[shadow_loaded & 15] = v;
      shadow_loaded++;
      if (shadow_loaded < n * n) return;
      shadow_loaded = 0;
      m = '{default: 0};
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            m[i][j] = longint'(shadow_store[i * n + j]);
      last_det = matrix_det(m, n);
      if (last_det == 0) begin
         e = '{row: '0, col: '0, inv: '0, adj: '0, det: '0, sing: 1'b1, last: 1'b1};
         pending_results.push_back(e);
         return;
      end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            // adjugate entry (i,j) is the cofactor of (j,i)
            strike(m, n, j, i, sub);
            cof = minor_det(sub, n - 1);
            if ((i + j) & 1) cof = -cof;
            inv = (cof * 65536) / last_det;
            e.row  = mic_pkg::IDX_W'(i);
            e.col  = mic_pkg::IDX_W'(j);
            e.inv  = mic_pkg::INV_W'(inv);
            e.adj  = mic_pkg::MINOR_W'(cof);
            e.det  = mic_pkg::DET_W'(last_det);
            e.sing = 1'b0;
            e.last = (i == n - 1 && j == n - 1);
            pending_results.push_back(e);
         end
   endfunction

   // Result checker: outputs are read at the rising edge, before the block updates.
   always @(posedge clock) begin
      inv_entry_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result row=%0d col=%0d", rsp_row_index, rsp_column_index);
            failed = 1'b1;
         end else begin
            e = pending_results.pop_front();
            if (rsp_row_index !== e.row) begin
               $error("row_index: expected %0d, got %0d", e.row, rsp_row_index);
               failed = 1'b1;
            end
            if (rsp_column_index !== e.col) begin
               $error("column_index: expected %0d, got %0d", e.col, rsp_column_index);
               failed = 1'b1;
            end
            if (rsp_inverse_value !== e.inv) begin
               $error("inverse_value: expected %0d, got %0d",
                      $signed(e.inv), rsp_inverse_value);
               failed = 1'b1;
            end
            if (rsp_adjugate_value !== e.adj) begin
               $error("adjugate_value: expected %0d, got %0d",
                      $signed(e.adj), rsp_adjugate_value);
               failed = 1'b1;
            end
            if (rsp_determinant !== e.det) begin
               $error("determinant: expected %0d, got %0d", $signed(e.det), rsp_determinant);
               failed = 1'b1;
            end
            if (rsp_singular !== e.sing) begin
               $error("singular: expected %0d, got %0d", e.sing, rsp_singular);
               failed = 1'b1;
            end
            if (rsp_last_result !== e.last) begin
               $error("last_result: expected %0d, got %0d", e.last, rsp_last_result);
               failed = 1'b1;
            end
         end
      end
   end

   // Offer one item; called and returning at a falling edge. Idle the sender
   // first at random, otherwise keep start high back to back.
   task automatic send_entry(input logic signed [mic_pkg::ENTRY_W-1:0] v);
      int gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(8, 1);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_entry_value <= v;
      do @(posedge clock); while (busy);
      load_entry(v);
      @(negedge clock);
   endtask

   // Hold the sender until every queued result is out.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0 || busy) @(negedge clock);
   endtask

   // Write the order only while idle; give a run still computing time to finish.
   task automatic write_order(input logic [mic_pkg::SIZE_W-1:0] v);
      drain();
      repeat (20) @(negedge clock);
      while (busy) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_order = v;
      shadow_loaded = 0;
   endtask

   // Directed rows: extremes, identity, singular, a clamped order and a
   // size change in the middle of a load.
   table_row_type directed [] = '{
      '{ROW_ORDER, 2, 0, 0},
      '{ROW_ENTRY, 1, 0, 0}, '{ROW_ENTRY, 0, 0, 0}, '{ROW_ENTRY, 0, 0, 0},
      '{ROW_ENTRY, 1, 1, 1},
      '{ROW_ENTRY, -128, 0, 0}, '{ROW_ENTRY, 127, 0, 0}, '{ROW_ENTRY, 127, 0, 0},
      '{ROW_ENTRY, -128, 1, 255},
      '{ROW_ENTRY, 0, 0, 0}, '{ROW_ENTRY, 0, 0, 0}, '{ROW_ENTRY, 0, 0, 0},
      '{ROW_ENTRY, 0, 1, 0},
      '{ROW_ORDER, 0, 0, 0},
      '{ROW_ENTRY, 127, 0, 0}, '{ROW_ENTRY, -128, 0, 0}, '{ROW_ENTRY, -128, 0, 0},
      '{ROW_ENTRY, 127, 1, -255},
      '{ROW_ENTRY, 5, 0, 0}, '{ROW_ENTRY, -7, 0, 0},
      '{ROW_ORDER, 3, 0, 0},
      '{ROW_ENTRY, 2, 0, 0}, '{ROW_ENTRY, 0, 0, 0}, '{ROW_ENTRY, 0, 0, 0},
      '{ROW_ENTRY, 0, 0, 0}, '{ROW_ENTRY, -1, 0, 0}, '{ROW_ENTRY, 0, 0, 0},
      '{ROW_ENTRY, 0, 0, 0}, '{ROW_ENTRY, 0, 0, 0}, '{ROW_ENTRY, 3, 1, -6}
   };

   // Send one matrix of the active order. Mix full-range entries, small
   // entries (often singular) and copied rows (always singular).
   task automatic send_matrix();
      int n, style;
      logic signed [mic_pkg::ENTRY_W-1:0] row0 [4];
      logic signed [mic_pkg::ENTRY_W-1:0] v;
      n = active_order();
      style = $urandom_range(99);
      for (int k = 0; k < n * n; k++) begin
         if (style < 70) v = mic_pkg::ENTRY_W'($urandom);
         else if (style < 88) v = mic_pkg::ENTRY_W'($urandom_range(4)) - 8'sd2;
         else v = (k >= n && k < 2 * n) ? row0[k - n] : mic_pkg::ENTRY_W'($urandom);
         if (k < n) row0[k] = v;
         send_entry(v);
      end
   endtask

   initial begin
      int sent;
      int idle_mix [4];
      idle_mix = '{0, 80, 0, 27};
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      shadow_order = mic_pkg::SIZE_RESET;
      shadow_loaded = 0;
      @(negedge clock);

      // Directed table; typed determinants cross-check the predictor.
      foreach (directed[r]) begin
         if (directed[r].kind == ROW_ORDER) begin
            write_order(mic_pkg::SIZE_W'(directed[r].value));
         end else begin
            send_entry(mic_pkg::ENTRY_W'(directed[r].value));
            if (directed[r].has_det && last_det != directed[r].det) begin
               $error("determinant: expected %0d, got %0d", directed[r].det, last_det);
               failed = 1'b1;
            end
         end
      end
      drain();

      // Random matrices under each idling mix; the order changes between
      // matrices and now and then a load is cut short by an order write.
      sent = 0;
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = idle_mix[p];
         write_order(p == 0 ? 3'd4 : mic_pkg::SIZE_W'($urandom_range(7)));
         while (sent < 58 * (p + 1)) begin
            case ($urandom_range(9))
               0: write_order(mic_pkg::SIZE_W'($urandom_range(7)));
               1: begin
                  // broken load: a few entries, then restart via an order write
                  repeat ($urandom_range(3, 1)) send_entry(mic_pkg::ENTRY_W'($urandom));
                  write_order(mic_pkg::SIZE_W'($urandom_range(7)));
               end
               2: drain();
               default: ;
            endcase
            send_matrix();
            sent += active_order() * active_order();
         end
      end

      drain();
      repeat (50) @(negedge clock);
      if (!failed && pending_results.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
